// File: hdl/cooperative_task_scheduler_assert.svh
// assertion macros for the task scheduler
`ifndef COOPERATIVE_TASK_SCHEDULER_ASSERT_SVH
`define COOPERATIVE_TASK_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CTS_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scheduler check failed");
`define CTS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("scheduler sequence check failed");
`else
`define CTS_ASSERT_IMPL(label, clk, rst_n, prop)
`define CTS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: hdl/cts_pkg.sv
// shared types and codes for the task scheduler
package cts_pkg;

    localparam int unsigned TASKS = 16;
    localparam int unsigned CMD_W = 3;
    localparam int unsigned ID_W  = 4;
    localparam int unsigned STS_W = 2;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_DISPATCH = 3'd1,
        CMD_REPORT   = 3'd2,
        CMD_SUSPEND  = 3'd3,
        CMD_RESUME   = 3'd4,
        CMD_RESUME_ALL = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NO_READY = 2'd1,
        STS_BAD_TASK = 2'd2,
        STS_NO_SLOT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SLOT_FREE = 2'd0,
        SLOT_READY = 2'd1,
        SLOT_SUSP = 2'd2,
        SLOT_EXEC = 2'd3
    } t_slot;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_EXEC  = 2'd1,
        FSM_MOVE  = 2'd2
    } t_fsm;

    // controller to datapath
    typedef struct packed {
        logic latch;   // capture command and look at state
        logic exec;    // perform the single-step update and post result
        logic move;    // move one suspended head to ready tail
        logic finish;  // post ok result of resume-all
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic is_resume_all;
        logic susp_empty;
    } t_sts;

endpackage

// File: hdl/cts_ctrl.sv
// controller state machine for the task scheduler
module cts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cts_pkg::t_sts i_sts,
    output cts_pkg::t_ctl o_ctl
);
    import cts_pkg::*;

    t_fsm r_state;
    t_fsm n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        busy    = 1'b1;
        case (r_state)
            FSM_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_ctl.latch = 1'b1;
                    n_state = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (i_sts.is_resume_all) begin
                    if (i_sts.susp_empty) begin
                        o_ctl.finish = 1'b1;
                        n_state = FSM_IDLE;
                    end else begin
                        o_ctl.move = 1'b1;
                        n_state = FSM_MOVE;
                    end
                end else begin
                    o_ctl.exec = 1'b1;
                    n_state = FSM_IDLE;
                end
            end
            FSM_MOVE: begin
                if (i_sts.susp_empty) begin
                    o_ctl.finish = 1'b1;
                    n_state = FSM_IDLE;
                end else begin
                    o_ctl.move = 1'b1;
                end
            end
            default: n_state = FSM_IDLE;
        endcase
    end

endmodule

// File: hdl/cts_datapath.sv
// slot table, link memories and list registers of the task scheduler
module cts_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cts_pkg::t_ctl            i_ctl,
    output cts_pkg::t_sts            o_sts,
    input  logic                     i_term_req,
    input  logic [cts_pkg::CMD_W-1:0] i_cmd,
    input  logic [cts_pkg::ID_W-1:0]  i_task_id,
    input  logic                     i_completed,
    output logic                     o_valid,
    output logic [cts_pkg::STS_W-1:0] o_status,
    output logic [cts_pkg::ID_W-1:0]  o_task_out,
    output logic                     o_terminate_flag
);
    import cts_pkg::*;

    localparam int unsigned SW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int unsigned CW = $clog2(TASKS + 1);

    t_slot        r_slot [TASKS];
    logic [TASKS-1:0] r_want;
    logic [TASKS-1:0] r_skip;
    logic [SW-1:0] r_next [TASKS];
    logic [SW-1:0] r_prev [TASKS];
    logic [SW-1:0] r_rhead, r_rtail, r_shead, r_stail;
    logic [CW-1:0] r_rcnt, r_scnt;

    logic [CMD_W-1:0] r_cmd;
    logic [ID_W-1:0]  r_id;
    logic             r_done;
    logic             r_known;
    t_slot            r_tstate;
    logic             r_twant, r_tskip;
    logic [SW-1:0]    r_tnext, r_tprev;
    logic             r_free_found;
    logic [SW-1:0]    r_free_idx;

    logic [SW-1:0] tsel;
    logic          free_found;
    logic [SW-1:0] free_idx;

    assign tsel = r_id[SW-1:0];

    // lowest free slot, registered at command capture
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TASKS - 1; i >= 0; i--) begin
            if (r_slot[i] == SLOT_FREE) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    assign o_sts.is_resume_all = (r_cmd == CMD_RESUME_ALL);
    assign o_sts.susp_empty    = (r_scnt == '0);

    // removal/append decode for the exec step
    logic [SW-1:0] rem_t, app_t;
    logic          do_rem_r, do_rem_s, do_app_r, do_app_s;
    logic          set_exec, set_free, set_susp, set_ready, set_skip, set_want;
    logic [SW-1:0] ctgt;
    t_status       sts;
    logic [ID_W-1:0] tout;
    logic          term;
    logic          rem_first, rem_last;
    logic [SW-1:0] rem_next, rem_prev;
    logic          rem_ok;

    always_comb begin
        do_rem_r = 1'b0; do_rem_s = 1'b0; do_app_r = 1'b0; do_app_s = 1'b0;
        set_exec = 1'b0; set_free = 1'b0; set_susp = 1'b0; set_ready = 1'b0;
        set_skip = 1'b0; set_want = 1'b0;
        ctgt = tsel; sts = STS_OK; tout = '0; term = 1'b0;
        rem_t = tsel; app_t = tsel;
        if (i_ctl.move) begin
            rem_t = r_shead; app_t = r_shead; ctgt = r_shead;
            do_rem_s = 1'b1; do_app_r = 1'b1; set_ready = 1'b1;
        end else begin
            case (r_cmd)
                CMD_ADD: begin
                    if (r_free_found) begin
                        ctgt = r_free_idx; app_t = r_free_idx;
                        set_ready = 1'b1; do_app_r = 1'b1;
                        tout = ID_W'(r_free_idx);
                    end else begin
                        sts = STS_NO_SLOT;
                    end
                end
                CMD_DISPATCH: begin
                    if (r_rcnt == '0) begin
                        sts = STS_NO_READY;
                    end else begin
                        ctgt = r_rhead; rem_t = r_rhead;
                        do_rem_r = 1'b1; set_exec = 1'b1;
                        tout = ID_W'(r_rhead); term = i_term_req;
                    end
                end
                CMD_REPORT: begin
                    if (!r_known || r_tstate != SLOT_EXEC) begin
                        sts = STS_BAD_TASK;
                    end else if (r_done) begin
                        set_free = 1'b1;
                    end else if (r_twant && !r_tskip) begin
                        set_susp = 1'b1; do_app_s = 1'b1;
                    end else begin
                        set_ready = 1'b1; do_app_r = 1'b1;
                    end
                end
                CMD_SUSPEND: begin
                    if (!r_known || r_tstate == SLOT_FREE) sts = STS_BAD_TASK;
                    else set_want = 1'b1;
                end
                CMD_RESUME: begin
                    if (!r_known || r_tstate == SLOT_FREE) begin
                        sts = STS_BAD_TASK;
                    end else if (r_tstate == SLOT_EXEC) begin
                        set_skip = 1'b1;
                    end else if (r_tstate == SLOT_SUSP) begin
                        do_rem_s = 1'b1; do_app_r = 1'b1; set_ready = 1'b1;
                    end
                end
                CMD_RESUME_ALL: ;
                default: sts = STS_BAD_TASK;
            endcase
        end
    end

    // links of the removed entry: captured for task_id, otherwise a list head
    always_comb begin
        if (i_ctl.move || r_cmd == CMD_DISPATCH) begin
            rem_next = r_next[rem_t];
            rem_prev = r_prev[rem_t];
        end else begin
            rem_next = r_tnext;
            rem_prev = r_tprev;
        end
        rem_first = do_rem_r ? (rem_t == r_rhead) : (rem_t == r_shead);
        rem_last  = do_rem_r ? (rem_t == r_rtail) : (rem_t == r_stail);
        rem_ok    = do_rem_r ? (r_rcnt != '0) : (r_scnt != '0);
    end

    logic step;
    assign step = i_ctl.exec || i_ctl.move;

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd  <= i_cmd;
            r_id   <= i_task_id;
            r_done <= i_completed;
            r_known <= ({28'd0, i_task_id} < 32'(TASKS));
            r_tstate <= r_slot[i_task_id[SW-1:0]];
            r_twant <= r_want[i_task_id[SW-1:0]];
            r_tskip <= r_skip[i_task_id[SW-1:0]];
            r_tnext <= r_next[i_task_id[SW-1:0]];
            r_tprev <= r_prev[i_task_id[SW-1:0]];
            r_free_found <= free_found;
            r_free_idx <= free_idx;
        end
        // link memory updates; removal first, append may overwrite
        if (step && (do_rem_r || do_rem_s) && rem_ok) begin
            if (!rem_first) r_next[rem_prev] <= rem_next;
            if (!rem_last)  r_prev[rem_next] <= rem_prev;
        end
        if (step && do_app_r && (r_rcnt != '0 || (do_rem_r && rem_ok && r_rcnt == CW'(1))))
        begin
            r_next[r_rtail] <= app_t;
            r_prev[app_t]   <= r_rtail;
        end
        if (step && do_app_s && r_scnt != '0) begin
            r_next[r_stail] <= app_t;
            r_prev[app_t]   <= r_stail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASKS; i++) r_slot[i] <= SLOT_FREE;
            r_want <= '0; r_skip <= '0;
            r_rhead <= '0; r_rtail <= '0; r_rcnt <= '0;
            r_shead <= '0; r_stail <= '0; r_scnt <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_ctl.exec || i_ctl.finish;
            if (step) begin
                if (set_ready) r_slot[ctgt] <= SLOT_READY;
                if (set_exec)  r_slot[ctgt] <= SLOT_EXEC;
                if (set_susp)  r_slot[ctgt] <= SLOT_SUSP;
                if (set_free)  r_slot[ctgt] <= SLOT_FREE;
                if (set_want)  r_want[ctgt] <= 1'b1;
                if (set_skip)  r_skip[ctgt] <= 1'b1;
                if ((set_ready && r_cmd == CMD_ADD && !i_ctl.move) || set_exec || set_free)
                begin
                    r_want[ctgt] <= 1'b0;
                    r_skip[ctgt] <= 1'b0;
                end
                // ready list: dispatch removes; add, report, resume and moves append
                if (do_rem_r && rem_ok) begin
                    if (rem_first) r_rhead <= rem_next;
                    if (rem_last)  r_rtail <= rem_prev;
                    r_rcnt <= r_rcnt - CW'(1);
                end
                if (do_rem_s && rem_ok) begin
                    if (rem_first) r_shead <= rem_next;
                    if (rem_last)  r_stail <= rem_prev;
                end
                if (do_app_r) begin
                    if (r_rcnt == '0) r_rhead <= app_t;
                    r_rtail <= app_t;
                    r_rcnt  <= r_rcnt + CW'(1);
                end
                if (do_app_s) begin
                    if (r_scnt == '0) r_shead <= app_t;
                    r_stail <= app_t;
                end
                r_scnt <= r_scnt + CW'(do_app_s) - CW'(do_rem_s && rem_ok);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec || i_ctl.finish) begin
            o_status         <= i_ctl.finish ? STS_OK : sts;
            o_task_out       <= i_ctl.finish ? '0 : tout;
            o_terminate_flag <= i_ctl.finish ? 1'b0 : term;
        end
    end

endmodule

// File: hdl/cooperative_task_scheduler.sv
// Task-slot scheduler with FIFO ready queue and ordered suspended list.
// A command is taken when start is high and busy low. Each command
// produces one result on o_valid for one cycle: add, dispatch, report,
// suspend and resume read the state, then update; resume-all reads the
// state, then moves its N suspended tasks, one list move per cycle.
// The result cannot be stalled. terminate_request is written through
// i_cfg_valid/o_cfg_ready, which is always ready.
module cooperative_task_scheduler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_cmd,
    input  logic [3:0] i_task_id,
    input  logic       i_completed,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [3:0] o_task_out,
    output logic       o_terminate_flag
);
    import cts_pkg::*;

    `include "cooperative_task_scheduler_assert.svh"

    t_ctl ctl;
    t_sts sts;
    logic r_term_req;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_req <= 1'b0;
        end else if (i_cfg_valid) begin
            r_term_req <= i_cfg_data;
        end
    end

    cts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_sts(sts), .o_ctl(ctl)
    );

    cts_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_term_req(r_term_req), .i_cmd(i_cmd), .i_task_id(i_task_id),
        .i_completed(i_completed), .o_valid(o_valid), .o_status(o_status),
        .o_task_out(o_task_out), .o_terminate_flag(o_terminate_flag)
    );

    `CTS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `CTS_ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, o_valid |-> !busy)
    `CTS_ASSERT_IMPL(a_one_ctl, i_clk, i_rst_n, $onehot0({ctl.latch, ctl.exec, ctl.move, ctl.finish}))

endmodule
